// ===== hdl/lbbt_pkg.sv =====
// Shared types, field widths and codes for the label bounding box table.
`default_nettype none
package lbbt_pkg;

  localparam int unsigned MAX_LABELS_DEF = 1024;
  localparam int unsigned MAX_DIM        = 2048;

  localparam int LABEL_W = 10;
  localparam int COORD_W = 11;
  localparam int DIM_W   = 12;
  localparam int KERN_W  = 8;
  localparam int BOX_W   = 13;
  localparam int GROWN_W = 12;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W    = 2;
  localparam int EPOCH_W = 8;
  localparam int CALC_W  = 15;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_KERNEL_LENGTH = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic [KERN_W-1:0] kernel_length;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } box_t;

  // Table entry: a box tagged with the frame epoch it was written in.
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    box_t               box;
  } entry_t;

  // Lookup result handed from the table stage to the result stage.
  typedef struct packed {
    logic valid;
    logic seen;
    box_t box;
  } qry_t;

endpackage
`default_nettype wire

// ===== hdl/lbbt_cfg.sv =====
// Configuration registers: frame width, frame height and kernel length.
`default_nettype none
module lbbt_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [lbbt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lbbt_pkg::CFG_W-1:0]     cfg_data,
  output lbbt_pkg::cfg_t                      cfg
);
  import lbbt_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width   <= DIM_W'(640);
      cfg_r.frame_height  <= DIM_W'(480);
      cfg_r.kernel_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:   cfg_r.frame_width   <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT:  cfg_r.frame_height  <= cfg_data[DIM_W-1:0];
        CFG_KERNEL_LENGTH: cfg_r.kernel_length <= cfg_data[KERN_W-1:0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== hdl/lbbt_table.sv =====
// Extremes table: input register, epoch-tagged memory, read-modify-write with forwarding.
`default_nettype none
module lbbt_table #(
  parameter int unsigned MAX_LABELS = lbbt_pkg::MAX_LABELS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [lbbt_pkg::OP_W-1:0]    in_operation,
  input  wire logic [lbbt_pkg::LABEL_W-1:0] in_label,
  input  wire logic [lbbt_pkg::COORD_W-1:0] in_pixel_x,
  input  wire logic [lbbt_pkg::COORD_W-1:0] in_pixel_y,
  input  wire logic                         adv,
  output lbbt_pkg::qry_t                    qry
);
  import lbbt_pkg::*;

  localparam int AW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int XW = ((AW > LABEL_W) ? AW : LABEL_W) + 1;
  localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_LABELS - 1);

  entry_t mem [MAX_LABELS];
  entry_t rd_r;

  logic               s1_valid_r;
  op_t                s1_op_r;
  logic [AW-1:0]      s1_addr_r;
  logic               s1_in_tab_r;
  logic [COORD_W-1:0] s1_px_r;
  logic [COORD_W-1:0] s1_py_r;

  logic               fwd_valid_r;
  logic [AW-1:0]      fwd_addr_r;
  entry_t             fwd_data_r;

  logic [EPOCH_W-1:0] epoch_r;
  logic               sweep_r;
  logic [AW-1:0]      sweep_cnt_r;

  logic [XW-1:0] lbl_ext;
  logic          in_tab;
  logic [AW-1:0] rd_addr;
  logic          accept;
  logic          s1_go;
  logic          clr_wrap;
  entry_t        cur;
  logic          seen;
  entry_t        merged;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  assign lbl_ext = XW'(in_label);
  assign in_tab  = lbl_ext < XW'(MAX_LABELS);
  assign rd_addr = in_tab ? lbl_ext[AW-1:0] : '0;

  // hold input while the result stage stalls, or a wrapping clear or the clearing pass owns the write port
  assign clr_wrap = s1_valid_r && (s1_op_r == OP_CLEAR) && (epoch_r == EPOCH_LAST);
  assign in_stall = !adv || sweep_r || clr_wrap;
  assign accept   = in_valid && !in_stall;
  assign s1_go    = s1_valid_r && adv;

  // take the last write when it hit the same entry as this read
  assign cur  = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : rd_r;
  assign seen = s1_in_tab_r && (cur.epoch == epoch_r);

  always_comb begin
    merged.epoch = epoch_r;
    if (seen) begin
      merged.box.left   = (s1_px_r < cur.box.left)   ? s1_px_r : cur.box.left;
      merged.box.right  = (s1_px_r > cur.box.right)  ? s1_px_r : cur.box.right;
      merged.box.top    = (s1_py_r < cur.box.top)    ? s1_py_r : cur.box.top;
      merged.box.bottom = (s1_py_r > cur.box.bottom) ? s1_py_r : cur.box.bottom;
    end else begin
      merged.box.left   = s1_px_r;
      merged.box.right  = s1_px_r;
      merged.box.top    = s1_py_r;
      merged.box.bottom = s1_py_r;
    end
  end

  always_comb begin
    if (sweep_r) begin
      wr_en   = 1'b1;
      wr_addr = sweep_cnt_r;
      wr_data = '0;
    end else begin
      wr_en   = s1_go && (s1_op_r == OP_ACCUM) && s1_in_tab_r;
      wr_addr = s1_addr_r;
      wr_data = merged;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r     <= op_t'(in_operation);
      s1_addr_r   <= rd_addr;
      s1_in_tab_r <= in_tab;
      s1_px_r     <= in_pixel_x;
      s1_py_r     <= in_pixel_y;
      fwd_addr_r  <= wr_addr;
      fwd_data_r  <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      epoch_r     <= EPOCH_FIRST;
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
    end else begin
      if (adv) begin
        s1_valid_r <= accept;
      end
      if (accept) begin
        fwd_valid_r <= wr_en;
      end
      if (s1_go && (s1_op_r == OP_CLEAR)) begin
        if (epoch_r == EPOCH_LAST) begin
          epoch_r     <= EPOCH_FIRST;
          sweep_r     <= 1'b1;
          sweep_cnt_r <= '0;
        end else begin
          epoch_r <= epoch_r + EPOCH_W'(1);
        end
      end else if (sweep_r) begin
        sweep_cnt_r <= sweep_cnt_r + AW'(1);
        if (sweep_cnt_r == ADDR_LAST) begin
          sweep_r <= 1'b0;
        end
      end
    end
  end

  assign qry.valid = s1_valid_r && (s1_op_r == OP_QUERY);
  assign qry.seen  = seen;
  assign qry.box   = cur.box;

endmodule
`default_nettype wire

// ===== hdl/lbbt_grow.sv =====
// Result stage: default box for unseen labels, grown and clamped box, output register.
`default_nettype none
module lbbt_grow (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire lbbt_pkg::qry_t                   qry,
  input  wire lbbt_pkg::cfg_t                   cfg,
  input  wire logic                             adv,
  output logic                                  out_valid,
  output logic signed [lbbt_pkg::BOX_W-1:0]     out_box_left,
  output logic signed [lbbt_pkg::BOX_W-1:0]     out_box_top,
  output logic signed [lbbt_pkg::BOX_W-1:0]     out_box_right,
  output logic signed [lbbt_pkg::BOX_W-1:0]     out_box_bottom,
  output logic signed [lbbt_pkg::GROWN_W-1:0]   out_grown_left,
  output logic signed [lbbt_pkg::GROWN_W-1:0]   out_grown_top,
  output logic signed [lbbt_pkg::GROWN_W-1:0]   out_grown_right,
  output logic signed [lbbt_pkg::GROWN_W-1:0]   out_grown_bottom
);
  import lbbt_pkg::*;

  localparam logic signed [CALC_W-1:0] CAP  = CALC_W'(MAX_DIM - 1);
  localparam logic signed [CALC_W-1:0] NEG1 = '1;
  localparam logic signed [CALC_W-1:0] ONE  = CALC_W'(1);

  function automatic logic signed [CALC_W-1:0] grow_lo(
    input logic signed [CALC_W-1:0] v,
    input logic signed [CALC_W-1:0] k
  );
    logic signed [CALC_W-1:0] d;
    d = v - k;
    if (d < 0) begin
      d = '0;
    end
    return (d > CAP) ? CAP : d;
  endfunction

  function automatic logic signed [CALC_W-1:0] grow_hi(
    input logic signed [CALC_W-1:0] v,
    input logic signed [CALC_W-1:0] k,
    input logic signed [CALC_W-1:0] bnd
  );
    logic signed [CALC_W-1:0] s;
    s = v + k;
    if (s > bnd) begin
      s = bnd;
    end
    return (s > CAP) ? CAP : s;
  endfunction

  logic signed [CALC_W-1:0] fw_c, fh_c, k_c;
  logic signed [CALC_W-1:0] l_c, t_c, r_c, b_c;

  logic                      out_valid_r;
  logic signed [BOX_W-1:0]   box_l_r, box_t_r, box_r_r, box_b_r;
  logic signed [GROWN_W-1:0] grw_l_r, grw_t_r, grw_r_r, grw_b_r;

  assign fw_c = signed'(CALC_W'(cfg.frame_width));
  assign fh_c = signed'(CALC_W'(cfg.frame_height));
  assign k_c  = signed'(CALC_W'(cfg.kernel_length));

  // unseen label: start values width, height, -1, -1
  assign l_c = qry.seen ? signed'(CALC_W'(qry.box.left))   : fw_c;
  assign t_c = qry.seen ? signed'(CALC_W'(qry.box.top))    : fh_c;
  assign r_c = qry.seen ? signed'(CALC_W'(qry.box.right))  : NEG1;
  assign b_c = qry.seen ? signed'(CALC_W'(qry.box.bottom)) : NEG1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= qry.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && qry.valid) begin
      box_l_r <= l_c[BOX_W-1:0];
      box_t_r <= t_c[BOX_W-1:0];
      box_r_r <= r_c[BOX_W-1:0];
      box_b_r <= b_c[BOX_W-1:0];
      grw_l_r <= GROWN_W'(grow_lo(l_c, k_c));
      grw_t_r <= GROWN_W'(grow_lo(t_c, k_c));
      grw_r_r <= GROWN_W'(grow_hi(r_c, k_c, fw_c - ONE));
      grw_b_r <= GROWN_W'(grow_hi(b_c, k_c, fh_c - ONE));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_box_left     = box_l_r;
  assign out_box_top      = box_t_r;
  assign out_box_right    = box_r_r;
  assign out_box_bottom   = box_b_r;
  assign out_grown_left   = grw_l_r;
  assign out_grown_top    = grw_t_r;
  assign out_grown_right  = grw_r_r;
  assign out_grown_bottom = grw_b_r;

endmodule
`default_nettype wire

// ===== hdl/label_bounding_box_table_core.sv =====
// Top level of the per-label bounding box table.
// A query beat is registered in the table stage and again in the result stage before
// it shows on the out_ channel. Throughput: one beat per cycle while in_stall is low;
// the table memory's single write port sets this. Every 255th clear holds in_stall high
// for a clearing pass over all entries. Reset (rst_n low, synchronous) loads 640 / 480 / 0
// into the registers and then runs the same clearing pass; config writes are taken throughout.
`default_nettype none
module label_bounding_box_table_core #(
  parameter int unsigned MAX_LABELS = lbbt_pkg::MAX_LABELS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [lbbt_pkg::OP_W-1:0]        in_operation,
  input  wire logic [lbbt_pkg::LABEL_W-1:0]     in_label,
  input  wire logic [lbbt_pkg::COORD_W-1:0]     in_pixel_x,
  input  wire logic [lbbt_pkg::COORD_W-1:0]     in_pixel_y,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [lbbt_pkg::BOX_W-1:0]     out_box_left,
  output logic signed [lbbt_pkg::BOX_W-1:0]     out_box_top,
  output logic signed [lbbt_pkg::BOX_W-1:0]     out_box_right,
  output logic signed [lbbt_pkg::BOX_W-1:0]     out_box_bottom,
  output logic signed [lbbt_pkg::GROWN_W-1:0]   out_grown_left,
  output logic signed [lbbt_pkg::GROWN_W-1:0]   out_grown_top,
  output logic signed [lbbt_pkg::GROWN_W-1:0]   out_grown_right,
  output logic signed [lbbt_pkg::GROWN_W-1:0]   out_grown_bottom,
  // configuration port
  input  wire logic                             cfg_we,
  input  wire logic [lbbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lbbt_pkg::CFG_W-1:0]       cfg_data
);
  import lbbt_pkg::*;

  cfg_t cfg;
  qry_t qry;
  logic adv;

  // Advance the whole pipe whenever the output register is empty or its beat
  // is being taken; a stalled result freezes the table stage behind it.
  assign adv = !out_valid || !out_stall;

  lbbt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Table stage: registered read of the label's entry, merge of the pixel,
  // write back when the stage advances; the last write is forwarded to a read of
  // the same entry that was issued at the same edge. Clears bump the epoch tag
  // instead of touching the memory, but the wrapping clear starts a clearing pass.
  lbbt_table #(
    .MAX_LABELS (MAX_LABELS)
  ) u_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_label     (in_label),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .adv          (adv),
    .qry          (qry)
  );

  // Result stage: substitute the start box for unseen labels, grow by the
  // kernel length, clamp to the frame and hold the beat until taken.
  lbbt_grow u_grow (
    .clk              (clk),
    .rst_n            (rst_n),
    .qry              (qry),
    .cfg              (cfg),
    .adv              (adv),
    .out_valid        (out_valid),
    .out_box_left     (out_box_left),
    .out_box_top      (out_box_top),
    .out_box_right    (out_box_right),
    .out_box_bottom   (out_box_bottom),
    .out_grown_left   (out_grown_left),
    .out_grown_top    (out_grown_top),
    .out_grown_right  (out_grown_right),
    .out_grown_bottom (out_grown_bottom)
  );

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the per-label bounding box table core.
`timescale 1ns / 100ps
module tb;
  import lbbt_pkg::*;

  // Operation code 3 is not in the package enum; the block must ignore it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Every grown field is capped at MAX_DIM - 1.
  localparam int GROWN_CAP = int'(MAX_DIM) - 1;

  // Long receiver hold-off used to back the pipeline up into in_stall.
  localparam int LONG_HOLD = 300;

  // Idle-cycle watchdog. The slowest legal quiet stretch is a clearing pass
  // plus the long hold-off plus a long sender gap; allow many times that.
  localparam int IDLE_LIMIT = 20000;

  // Random beats aimed at each configuration phase.
  localparam int PHASE_BEATS = 70;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [LABEL_W-1:0] label;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pix_beat_t;

  typedef struct {
    logic signed [BOX_W-1:0]   box_left;
    logic signed [BOX_W-1:0]   box_top;
    logic signed [BOX_W-1:0]   box_right;
    logic signed [BOX_W-1:0]   box_bottom;
    logic signed [GROWN_W-1:0] grown_left;
    logic signed [GROWN_W-1:0] grown_top;
    logic signed [GROWN_W-1:0] grown_right;
    logic signed [GROWN_W-1:0] grown_bottom;
  } box_result_t;

  typedef struct {
    cfg_idx_t         idx;
    logic [CFG_W-1:0] data;
  } reg_write_t;

  // Clock, reset and DUT inputs: known from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_operation = '0;
  logic [LABEL_W-1:0]   in_label = '0;
  logic [COORD_W-1:0]   in_pixel_x = '0;
  logic [COORD_W-1:0]   in_pixel_y = '0;

  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [BOX_W-1:0]     out_box_left;
  logic signed [BOX_W-1:0]     out_box_top;
  logic signed [BOX_W-1:0]     out_box_right;
  logic signed [BOX_W-1:0]     out_box_bottom;
  logic signed [GROWN_W-1:0]   out_grown_left;
  logic signed [GROWN_W-1:0]   out_grown_top;
  logic signed [GROWN_W-1:0]   out_grown_right;
  logic signed [GROWN_W-1:0]   out_grown_bottom;

  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  // Shadow of the block: one box and one valid flag per label, plus registers.
  logic [COORD_W-1:0] tbl_left   [MAX_LABELS_DEF];
  logic [COORD_W-1:0] tbl_top    [MAX_LABELS_DEF];
  logic [COORD_W-1:0] tbl_right  [MAX_LABELS_DEF];
  logic [COORD_W-1:0] tbl_bottom [MAX_LABELS_DEF];
  bit                 label_valid[MAX_LABELS_DEF];
  logic [DIM_W-1:0]   cur_width  = 12'd640;
  logic [DIM_W-1:0]   cur_height = 12'd480;
  logic [KERN_W-1:0]  cur_kernel = 8'd0;

  // Beats waiting to be sent, register writes waiting, query answers due.
  pix_beat_t   beats_to_send[$];
  reg_write_t  cfg_writes[$];
  box_result_t boxes_due[$];

  int  err_cnt = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  holds_asked = 0;
  int  holds_served = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;

  always #5 clk = ~clk;

  label_bounding_box_table_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_label         (in_label),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_box_left     (out_box_left),
    .out_box_top      (out_box_top),
    .out_box_right    (out_box_right),
    .out_box_bottom   (out_box_bottom),
    .out_grown_left   (out_grown_left),
    .out_grown_top    (out_grown_top),
    .out_grown_right  (out_grown_right),
    .out_grown_bottom (out_grown_bottom),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Advance the shadow table by one accepted beat; queue the answer of a query.
  task automatic update_box_table(input pix_beat_t b);
    box_result_t res;
    int l, t, r, w, k, gl, gt, gr, gb;
    case (b.op)
      OP_CLEAR: begin
        foreach (label_valid[i]) label_valid[i] = 1'b0;
      end
      OP_ACCUM: begin
        if (!label_valid[b.label]) begin
          // First pixel of the label in this frame: the box is that point.
          tbl_left[b.label]   = b.x;
          tbl_right[b.label]  = b.x;
          tbl_top[b.label]    = b.y;
          tbl_bottom[b.label] = b.y;
          label_valid[b.label] = 1'b1;
        end else begin
          if (b.x < tbl_left[b.label])   tbl_left[b.label]   = b.x;
          if (b.x > tbl_right[b.label])  tbl_right[b.label]  = b.x;
          if (b.y < tbl_top[b.label])    tbl_top[b.label]    = b.y;
          if (b.y > tbl_bottom[b.label]) tbl_bottom[b.label] = b.y;
        end
      end
      OP_QUERY: begin
        k = int'(cur_kernel);
        if (label_valid[b.label]) begin
          l = int'(tbl_left[b.label]);
          t = int'(tbl_top[b.label]);
          r = int'(tbl_right[b.label]);
          w = int'(tbl_bottom[b.label]);
        end else begin
          // Unseen label: inverted box that spans nothing.
          l = int'(cur_width);
          t = int'(cur_height);
          r = -1;
          w = -1;
        end
        gl = (l - k < 0) ? 0 : l - k;
        if (gl > GROWN_CAP) gl = GROWN_CAP;
        gt = (t - k < 0) ? 0 : t - k;
        if (gt > GROWN_CAP) gt = GROWN_CAP;
        gr = r + k;
        if (gr > int'(cur_width) - 1) gr = int'(cur_width) - 1;
        if (gr > GROWN_CAP) gr = GROWN_CAP;
        gb = w + k;
        if (gb > int'(cur_height) - 1) gb = int'(cur_height) - 1;
        if (gb > GROWN_CAP) gb = GROWN_CAP;
        res.box_left     = BOX_W'(l);
        res.box_top      = BOX_W'(t);
        res.box_right    = BOX_W'(r);
        res.box_bottom   = BOX_W'(w);
        res.grown_left   = GROWN_W'(gl);
        res.grown_top    = GROWN_W'(gt);
        res.grown_right  = GROWN_W'(gr);
        res.grown_bottom = GROWN_W'(gb);
        boxes_due = {boxes_due, res};
      end
      default: ;
    endcase
  endtask

  // Sender gap after a beat: mostly none, some short, a few long.
  function automatic int next_gap();
    int r;
    if (!send_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Input driver: register writes first, then pixel beats from the queue.
  always @(posedge clk) begin : drive_beats
    pix_beat_t acc_b;
    pix_beat_t nb;
    reg_write_t wr;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_we   <= 1'b0;
      send_gap = 0;
    end else begin
      // Apply the register write that lands on this edge to the shadow.
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:   cur_width  = cfg_data;
          CFG_FRAME_HEIGHT:  cur_height = cfg_data;
          CFG_KERNEL_LENGTH: cur_kernel = cfg_data[KERN_W-1:0];
          default: ;
        endcase
      end
      if (cfg_writes.size() != 0) begin
        wr = cfg_writes.pop_front();
        cfg_we    <= 1'b1;
        cfg_index <= wr.idx;
        cfg_data  <= wr.data;
      end else begin
        cfg_we <= 1'b0;
      end

      if (in_valid && !in_stall) begin
        acc_b.op    = in_operation;
        acc_b.label = in_label;
        acc_b.x     = in_pixel_x;
        acc_b.y     = in_pixel_y;
        update_box_table(acc_b);
        send_gap = next_gap();
      end

      // Hold a stalled beat; otherwise idle out the gap or offer the next one.
      if (in_valid && in_stall) begin
      end else if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (beats_to_send.size() != 0) begin
        nb = beats_to_send.pop_front();
        in_valid     <= 1'b1;
        in_operation <= nb.op;
        in_label     <= nb.label;
        in_pixel_x   <= nb.x;
        in_pixel_y   <= nb.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_cnt++;
      $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Result monitor and receiver stall generator.
  always @(posedge clk) begin : watch_results
    box_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (boxes_due.size() == 0) begin
          err_cnt++;
          $display("%0t unexpected beat: expected none, got box %0d %0d %0d %0d", $time,
                   out_box_left, out_box_top, out_box_right, out_box_bottom);
        end else begin
          want = boxes_due.pop_front();
          check_field("box_left",     want.box_left,     out_box_left);
          check_field("box_top",      want.box_top,      out_box_top);
          check_field("box_right",    want.box_right,    out_box_right);
          check_field("box_bottom",   want.box_bottom,   out_box_bottom);
          check_field("grown_left",   want.grown_left,   out_grown_left);
          check_field("grown_top",    want.grown_top,    out_grown_top);
          check_field("grown_right",  want.grown_right,  out_grown_right);
          check_field("grown_bottom", want.grown_bottom, out_grown_bottom);
        end
      end
      // A requested long hold-off wins over random stalls.
      if (holds_served != holds_asked) begin
        holds_served++;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && recv_idle && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: drop the run after too many cycles with no beat and no write.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb NOT OK");
    $finish;
  end

  task automatic add_beat(input logic [OP_W-1:0] op, input logic [LABEL_W-1:0] lbl,
                          input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    pix_beat_t b;
    b.op    = op;
    b.label = lbl;
    b.x     = x;
    b.y     = y;
    beats_to_send = {beats_to_send, b};
  endtask

  // Coordinate mostly inside the frame, sometimes anywhere in the field.
  function automatic logic [COORD_W-1:0] rand_coord(input logic [DIM_W-1:0] dim);
    int lim;
    if (dim == 0 || $urandom_range(0, 7) == 0) return COORD_W'($urandom_range(0, 2047));
    lim = (dim > 2048) ? 2048 : int'(dim);
    return COORD_W'($urandom_range(0, lim - 1));
  endfunction

  // Wait until every beat is sent, every write landed and every answer is in,
  // then let the pipeline flush clears and accumulates.
  task automatic wait_drained();
    while (beats_to_send.size() != 0 || in_valid || boxes_due.size() != 0 ||
           cfg_writes.size() != 0 || cfg_we)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One frame: a clear, then accumulates and queries on a few labels, with
  // some stray labels, ignored codes and mid-frame clears as noise.
  task automatic add_frame(output int n_counted);
    logic [LABEL_W-1:0] pool[4];
    logic [LABEL_W-1:0] lbl;
    int len, r;
    n_counted = 1;
    add_beat(OP_CLEAR, LABEL_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    foreach (pool[i]) pool[i] = LABEL_W'($urandom);
    if ($urandom_range(0, 3) == 0) pool[0] = '0;
    if ($urandom_range(0, 3) == 0) pool[3] = '1;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(3, 25);
    repeat (len) begin
      r = $urandom_range(0, 99);
      lbl = ($urandom_range(0, 6) == 0) ? LABEL_W'($urandom) : pool[$urandom_range(0, 3)];
      if (r < 55) begin
        add_beat(OP_ACCUM, lbl, rand_coord(cur_width), rand_coord(cur_height));
        n_counted++;
      end else if (r < 90) begin
        add_beat(OP_QUERY, lbl, COORD_W'($urandom), COORD_W'($urandom));
        n_counted++;
      end else if (r < 96) begin
        add_beat(OP_UNUSED, LABEL_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
      end else begin
        add_beat(OP_CLEAR, LABEL_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
        n_counted++;
      end
    end
  endtask

  // Reprogram the registers while idle, then run random frames under them.
  task automatic run_phase(input int fw, input int fh, input int kl, input bit pressure);
    reg_write_t wr;
    int got, n;
    wait_drained();
    wr.idx = CFG_FRAME_WIDTH;   wr.data = CFG_W'(fw); cfg_writes = {cfg_writes, wr};
    wr.idx = CFG_FRAME_HEIGHT;  wr.data = CFG_W'(fh); cfg_writes = {cfg_writes, wr};
    // Upper data bits of the kernel write carry noise; the register keeps 8 bits.
    wr.idx = CFG_KERNEL_LENGTH;
    wr.data = {4'($urandom), KERN_W'(kl)};
    cfg_writes = {cfg_writes, wr};
    wait_drained();
    got = 0;
    if (pressure) begin
      // Hold the receiver off while a dense burst streams in.
      send_idle = 1'b0;
      holds_asked++;
      repeat (40) begin
        add_beat(OP_ACCUM, 10'd7, rand_coord(cur_width), rand_coord(cur_height));
        add_beat(OP_QUERY, 10'd7, COORD_W'($urandom), COORD_W'($urandom));
        got += 2;
      end
    end
    while (got < PHASE_BEATS) begin
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      add_frame(n);
      got += n;
      // Keep the queue short so idle modes change while beats still flow.
      while (beats_to_send.size() > 8) @(negedge clk);
    end
  endtask

  initial begin : stimulus
    logic [LABEL_W-1:0] storm_lbls[$];
    logic [LABEL_W-1:0] lbl;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset register values.
    add_beat(OP_QUERY, 10'd0, 11'd0, 11'd0);          // unseen label
    add_beat(OP_ACCUM, 10'd0, 11'd0, 11'd0);
    add_beat(OP_QUERY, 10'd0, 11'h7FF, 11'h7FF);      // read right behind the write
    add_beat(OP_ACCUM, 10'd0, 11'd2047, 11'd2047);    // pixel outside the frame
    add_beat(OP_ACCUM, 10'd0, 11'd3, 11'd2047);
    add_beat(OP_QUERY, 10'd0, 11'd0, 11'd0);
    add_beat(OP_ACCUM, 10'd1023, 11'd2047, 11'd0);
    add_beat(OP_ACCUM, 10'd1023, 11'd0, 11'd2047);
    add_beat(OP_QUERY, 10'd1023, 11'd0, 11'd0);
    add_beat(OP_UNUSED, 10'd1023, 11'd2047, 11'd2047); // ignored code
    add_beat(OP_QUERY, 10'd1023, 11'd0, 11'd0);
    add_beat(OP_ACCUM, 10'h200, 11'h555, 11'h2AA);
    add_beat(OP_ACCUM, 10'h200, 11'h2AA, 11'h555);
    add_beat(OP_QUERY, 10'h200, 11'd0, 11'd0);
    add_beat(OP_CLEAR, 10'h3FF, 11'h7FF, 11'h7FF);
    add_beat(OP_QUERY, 10'd0, 11'd0, 11'd0);          // dropped by the clear
    add_beat(OP_QUERY, 10'd1023, 11'd0, 11'd0);
    add_beat(OP_ACCUM, 10'd0, 11'd5, 11'd6);
    add_beat(OP_QUERY, 10'd0, 11'd0, 11'd0);
    add_beat(OP_CLEAR, 10'd0, 11'd0, 11'd0);
    add_beat(OP_CLEAR, 10'd0, 11'd0, 11'd0);
    add_beat(OP_QUERY, 10'd0, 11'd0, 11'd0);
    wait_drained();

    // Clear storm: run past the frame tag wrap so the clearing pass must hide
    // boxes left from many frames ago.
    add_beat(OP_ACCUM, 10'd100, 11'd1, 11'd2);
    add_beat(OP_ACCUM, 10'd200, 11'd300, 11'd400);
    for (int i = 1; i <= 300; i++) begin
      add_beat(OP_CLEAR, LABEL_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
      if (i % 25 == 0) begin
        lbl = LABEL_W'($urandom);
        storm_lbls = {storm_lbls, lbl};
        add_beat(OP_ACCUM, lbl, rand_coord(cur_width), rand_coord(cur_height));
        add_beat(OP_QUERY, lbl, COORD_W'($urandom), COORD_W'($urandom));
      end
      if (i >= 250 && i <= 262)
        add_beat(OP_QUERY, storm_lbls[$urandom_range(0, storm_lbls.size() - 1)],
                 COORD_W'($urandom), COORD_W'($urandom));
      if (i == 255) add_beat(OP_QUERY, 10'd100, 11'd0, 11'd0);
      while (beats_to_send.size() > 8) @(negedge clk);
    end

    // Random frames across register settings, extremes first.
    run_phase(640, 480, 0, 1'b0);
    run_phase(1, 1, 255, 1'b0);
    run_phase(2048, 2048, 255, 1'b0);
    run_phase(2048, 2048, 0, 1'b1);
    run_phase(0, 0, 7, 1'b0);          // zero frame size
    run_phase(4095, 4095, 1, 1'b0);    // bounds above the grown cap
    run_phase($urandom_range(1, 2048), $urandom_range(1, 2048), $urandom_range(0, 255),
              1'b0);
    run_phase($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 16), 1'b0);

    wait_drained();
    repeat (8) @(negedge clk);
    if (err_cnt == 0 && boxes_due.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lbbt_pkg.sv
hdl/lbbt_cfg.sv
hdl/lbbt_table.sv
hdl/lbbt_grow.sv
hdl/label_bounding_box_table_core.sv
dv/tb.sv
